/* design/terminal_mouse_report_parser_defines.svh */
// Assertion macros used by the checker file of this block.
`ifndef TERMINAL_MOUSE_REPORT_PARSER_DEFINES_SVH
`define TERMINAL_MOUSE_REPORT_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMRP_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("terminal mouse report parser check failed");

// The consequent must hold in the cycle after the antecedent.
`define TMRP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("terminal mouse report parser check failed");

`endif

/* design/tmrp_pkg.sv */
package tmrp_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ESC,
    PH_CSI,
    PH_LEGACY,
    PH_SGR
  } phase_t;

  typedef enum logic [1:0] {
    ST_MORE     = 2'd0,
    ST_EVENT    = 2'd1,
    ST_NOTMOUSE = 2'd2,
    ST_DISCARD  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    KIND_LEGACY  = 2'd0,
    KIND_PRESS   = 2'd1,
    KIND_RELEASE = 2'd2
  } kind_t;

  localparam logic [1:0] FIELD_BUTTON = 2'd0;
  localparam logic [1:0] FIELD_X      = 2'd1;
  localparam logic [1:0] FIELD_Y      = 2'd2;

  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_UPPER_M  = 8'h4D;
  localparam logic [7:0] CH_LOWER_M  = 8'h6D;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  localparam logic [7:0] UTF8_LEAD2_MIN = 8'hC2;
  localparam logic [7:0] UTF8_LEAD2_MAX = 8'hDF;
  localparam logic [7:0] UTF8_LONG_MIN  = 8'hE0;
  localparam logic [7:0] UTF8_LONG_MAX  = 8'hF4;

  localparam int          LEGACY_W      = 11;
  localparam logic [7:0]  LEN_CSI       = 8'd3;
  localparam logic [7:0]  LEN_MAX       = 8'd255;
  localparam logic [10:0] LEGACY_BTN_OFS = 11'd32;
  localparam logic [10:0] LEGACY_POS_OFS = 11'd33;
  localparam logic [10:0] LEGACY_WRAP    = 11'd256;

  // Legacy coordinates below the offset map to 256 minus the coded value.
  function automatic logic [LEGACY_W-1:0] legacy_coord(input logic [LEGACY_W-1:0] v);
    logic [LEGACY_W-1:0] r;
    if (v >= LEGACY_POS_OFS) begin
      r = v - LEGACY_POS_OFS;
    end else begin
      r = LEGACY_WRAP - v;
    end
    return r;
  endfunction

endpackage

/* design/terminal_mouse_report_parser.sv */
// Terminal mouse report parser.
// Raw terminal bytes enter on the input channel (in_valid, in_ready, data_byte).
// Every accepted byte produces exactly one result item on the output channel
// (out_valid, out_ready and the result fields), in byte order.
// The result of a byte is registered and shows on the output channel in the cycle
// after the byte is accepted.
// Unless the output stalls, one byte can be accepted in every cycle, since each byte
// only updates a small parser state through one logic level into the result register.
// The single result register decides the rate under backpressure: a new byte is
// taken whenever that register is empty or its item is taken in the same cycle.
// When the receiver stalls, the result item holds unchanged and in_ready stays
// low until the item is taken.
// The cfg channel (cfg_valid, cfg_ready, cfg_data) writes the UTF-8 mode bit and
// is always ready; it should be written only while the parser is idle.
// Synchronous reset returns the parser to idle, clears the mode bit, the
// accumulators and the kept previous event, and empties the result register.
module terminal_mouse_report_parser #(
  parameter int COORD_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [7:0]  consumed_length,
  output logic [15:0] button,
  output logic [15:0] pos_x,
  output logic [15:0] pos_y,
  output logic [15:0] prev_x,
  output logic [15:0] prev_y,
  output logic [15:0] prev_button,
  output logic [1:0]  sgr_kind,
  output logic [15:0] sgr_raw_button
);
  import tmrp_pkg::*;

  localparam int AW = COORD_WIDTH + 4;
  localparam logic [AW-1:0] ACC_MAX = {4'b0000, {COORD_WIDTH{1'b1}}};

  logic                   utf8_mode;
  phase_t                 phase, phase_next;
  logic [1:0]             field, field_next;
  logic                   pending, pending_next;
  logic [7:0]             lead, lead_next;
  logic [COORD_WIDTH-1:0] acc_button, acc_button_next;
  logic [COORD_WIDTH-1:0] acc_x, acc_x_next;
  logic [COORD_WIDTH-1:0] acc_y, acc_y_next;
  logic [7:0]             count, count_next;
  logic [15:0]            last_x, last_x_next;
  logic [15:0]            last_y, last_y_next;
  logic [15:0]            last_button, last_button_next;

  logic                   fire;
  logic [7:0]             count_inc;
  logic                   is_lead2, is_long, lg_take;
  logic [LEGACY_W-1:0]    lg_value;
  logic                   is_digit, is_final, is_release;
  logic [COORD_WIDTH-1:0] acc_sel, digit_acc;
  logic [AW-1:0]          digit_sum;
  logic [COORD_WIDTH-1:0] ev_button, ev_x, ev_y, ev_raw;
  logic [31:0]            ev_button_w, ev_x_w, ev_y_w, ev_raw_w;
  kind_t                  ev_kind;
  status_t                res_status;
  logic [7:0]             res_len;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign fire      = in_valid && in_ready;

  assign count_inc = (count == LEN_MAX) ? LEN_MAX : count + 8'd1;

  assign is_lead2 = utf8_mode && data_byte >= UTF8_LEAD2_MIN && data_byte <= UTF8_LEAD2_MAX;
  assign is_long  = utf8_mode && data_byte >= UTF8_LONG_MIN && data_byte <= UTF8_LONG_MAX;
  assign lg_take  = pending || !(is_lead2 || is_long);
  assign lg_value = pending ? {lead[4:0], data_byte[5:0]} : {3'b000, data_byte};

  assign is_digit   = data_byte >= CH_ZERO && data_byte <= CH_NINE;
  assign is_release = data_byte == CH_LOWER_M;
  assign is_final   = data_byte == CH_UPPER_M || is_release;

  always_comb begin
    case (field)
      FIELD_BUTTON: acc_sel = acc_button;
      FIELD_X:      acc_sel = acc_x;
      default:      acc_sel = acc_y;
    endcase
  end

  // Decimal accumulate: acc * 10 + digit, clamped to the largest coordinate.
  assign digit_sum = {1'b0, acc_sel, 3'b000} + {3'b000, acc_sel, 1'b0} + AW'(data_byte[3:0]);
  assign digit_acc = (digit_sum > ACC_MAX) ? {COORD_WIDTH{1'b1}} : digit_sum[COORD_WIDTH-1:0];

  always_comb begin
    if (phase == PH_LEGACY) begin
      ev_button = acc_button - COORD_WIDTH'(LEGACY_BTN_OFS);
      ev_x      = COORD_WIDTH'(legacy_coord(acc_x[LEGACY_W-1:0]));
      ev_y      = COORD_WIDTH'(legacy_coord(lg_value));
      ev_raw    = '0;
      ev_kind   = KIND_LEGACY;
    end else begin
      ev_button = is_release ? (acc_button | COORD_WIDTH'(3)) : acc_button;
      ev_x      = acc_x - COORD_WIDTH'(1);
      ev_y      = acc_y - COORD_WIDTH'(1);
      ev_raw    = acc_button;
      ev_kind   = is_release ? KIND_RELEASE : KIND_PRESS;
    end
  end

  assign ev_button_w = 32'(ev_button);
  assign ev_x_w      = 32'(ev_x);
  assign ev_y_w      = 32'(ev_y);
  assign ev_raw_w    = 32'(ev_raw);

  // Result of the current byte.
  always_comb begin
    res_status = ST_NOTMOUSE;
    res_len    = 8'd0;
    case (phase)
      PH_IDLE: begin
        if (data_byte == CH_ESC) res_status = ST_MORE;
      end
      PH_ESC: begin
        if (data_byte == CH_LBRACKET) res_status = ST_MORE;
      end
      PH_CSI: begin
        if (data_byte == CH_UPPER_M || data_byte == CH_LT) begin
          res_status = ST_MORE;
          res_len    = LEN_CSI;
        end
      end
      PH_LEGACY: begin
        if (lg_take) begin
          res_len = count_inc;
          if (field != FIELD_Y) begin
            res_status = ST_MORE;
          end else if (acc_button >= COORD_WIDTH'(LEGACY_BTN_OFS)) begin
            res_status = ST_EVENT;
          end
        end else if (is_lead2) begin
          res_status = ST_MORE;
          res_len    = count_inc;
        end else begin
          res_len = count;
        end
      end
      PH_SGR: begin
        res_len = count_inc;
        if (field != FIELD_Y && data_byte == CH_SEMI) begin
          res_status = ST_MORE;
        end else if (field == FIELD_Y && is_final) begin
          if (acc_x == '0 || acc_y == '0) begin
            res_status = ST_NOTMOUSE;
          end else if (is_release && acc_button[6]) begin
            res_status = ST_DISCARD;
          end else begin
            res_status = ST_EVENT;
          end
        end else if (is_digit) begin
          res_status = ST_MORE;
        end
      end
      default: res_status = ST_NOTMOUSE;
    endcase
  end

  // Parser state update for the current byte.
  always_comb begin
    phase_next       = phase;
    field_next       = field;
    pending_next     = pending;
    lead_next        = lead;
    acc_button_next  = acc_button;
    acc_x_next       = acc_x;
    acc_y_next       = acc_y;
    count_next       = count;
    last_x_next      = last_x;
    last_y_next      = last_y;
    last_button_next = last_button;
    case (phase)
      PH_IDLE: phase_next = PH_ESC;
      PH_ESC:  phase_next = PH_CSI;
      PH_CSI: begin
        phase_next      = (data_byte == CH_UPPER_M) ? PH_LEGACY : PH_SGR;
        field_next      = FIELD_BUTTON;
        pending_next    = 1'b0;
        lead_next       = 8'd0;
        acc_button_next = '0;
        acc_x_next      = '0;
        acc_y_next      = '0;
        count_next      = LEN_CSI;
      end
      PH_LEGACY: begin
        if (lg_take) begin
          pending_next = 1'b0;
          count_next   = count_inc;
          case (field)
            FIELD_BUTTON: acc_button_next = COORD_WIDTH'(lg_value);
            FIELD_X:      acc_x_next      = COORD_WIDTH'(lg_value);
            default:      acc_y_next      = COORD_WIDTH'(lg_value);
          endcase
          if (field != FIELD_Y) field_next = field + 2'd1;
        end else if (is_lead2) begin
          lead_next    = data_byte;
          pending_next = 1'b1;
          count_next   = count_inc;
        end
      end
      PH_SGR: begin
        count_next = count_inc;
        if (field != FIELD_Y && data_byte == CH_SEMI) begin
          field_next = field + 2'd1;
        end else if (is_digit) begin
          case (field)
            FIELD_BUTTON: acc_button_next = digit_acc;
            FIELD_X:      acc_x_next      = digit_acc;
            default:      acc_y_next      = digit_acc;
          endcase
        end
      end
      default: phase_next = PH_IDLE;
    endcase
    if (res_status != ST_MORE) phase_next = PH_IDLE;
    if (res_status == ST_EVENT) begin
      last_x_next      = ev_x_w[15:0];
      last_y_next      = ev_y_w[15:0];
      last_button_next = ev_button_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      utf8_mode   <= 1'b0;
      phase       <= PH_IDLE;
      field       <= FIELD_BUTTON;
      pending     <= 1'b0;
      lead        <= 8'd0;
      acc_button  <= '0;
      acc_x       <= '0;
      acc_y       <= '0;
      count       <= 8'd0;
      last_x      <= 16'd0;
      last_y      <= 16'd0;
      last_button <= 16'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) utf8_mode <= cfg_data;
      if (fire) begin
        phase       <= phase_next;
        field       <= field_next;
        pending     <= pending_next;
        lead        <= lead_next;
        acc_button  <= acc_button_next;
        acc_x       <= acc_x_next;
        acc_y       <= acc_y_next;
        count       <= count_next;
        last_x      <= last_x_next;
        last_y      <= last_y_next;
        last_button <= last_button_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status          <= res_status;
      consumed_length <= res_len;
      if (res_status == ST_EVENT) begin
        button         <= ev_button_w[15:0];
        pos_x          <= ev_x_w[15:0];
        pos_y          <= ev_y_w[15:0];
        prev_x         <= last_x;
        prev_y         <= last_y;
        prev_button    <= last_button;
        sgr_kind       <= ev_kind;
        sgr_raw_button <= ev_raw_w[15:0];
      end else begin
        button         <= 16'd0;
        pos_x          <= 16'd0;
        pos_y          <= 16'd0;
        prev_x         <= 16'd0;
        prev_y         <= 16'd0;
        prev_button    <= 16'd0;
        sgr_kind       <= KIND_LEGACY;
        sgr_raw_button <= 16'd0;
      end
    end
  end

endmodule

/* design/tmrp_checker.sv */
`include "terminal_mouse_report_parser_defines.svh"

module tmrp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  consumed_length,
  input logic [15:0] button,
  input logic [15:0] pos_x,
  input logic [15:0] pos_y,
  input logic [15:0] prev_x,
  input logic [15:0] prev_y,
  input logic [15:0] prev_button,
  input logic [1:0]  sgr_kind,
  input logic [15:0] sgr_raw_button
);
  import tmrp_pkg::*;

  // A stalled result item keeps its contents.
  `TMRP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(consumed_length) && $stable(pos_x) && $stable(button))

  // With the result register empty the parser is always ready for a byte.
  `TMRP_ASSERT_SAME(a_empty_ready, !out_valid, in_ready)

  // Only a completed event carries event fields.
  `TMRP_ASSERT_SAME(a_fields_zero, out_valid && status != ST_EVENT, button == 16'd0 && pos_x == 16'd0 && pos_y == 16'd0 && prev_x == 16'd0 && prev_y == 16'd0 && prev_button == 16'd0 && sgr_kind == KIND_LEGACY && sgr_raw_button == 16'd0)

  // A delivered release has its low button bits set and is never a wheel release.
  `TMRP_ASSERT_SAME(a_release_bits, out_valid && status == ST_EVENT && sgr_kind == KIND_RELEASE, button[1:0] == 2'b11 && sgr_raw_button[6] == 1'b0)

  // A legacy event carries no raw SGR button.
  `TMRP_ASSERT_SAME(a_legacy_raw, out_valid && status == ST_EVENT && sgr_kind == KIND_LEGACY, sgr_raw_button == 16'd0)

endmodule

bind terminal_mouse_report_parser tmrp_checker u_tmrp_checker (.*);
